[rtl/tga_rle_scanline_decoder_unit_assert.svh]
// ----------------------------------------------------------------------------
// TGA RLE decoder assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_SCANLINE_DECODER_UNIT_ASSERT_SVH
`define TGA_RLE_SCANLINE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define TGA_RLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TGA_RLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tga_rle_pkg.sv]
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Field widths, header bit masks and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_rle_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_LENGTH  = 2'd0,
    REG_PIXEL_SIZE   = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] COUNT_MASK = 8'h7f;
  localparam logic [7:0] REPEAT_BIT = 8'h80;

  localparam logic [15:0] LINE_LENGTH_RST  = 16'd256;
  localparam logic [2:0]  PIXEL_SIZE_RST   = 3'd4;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd256;

  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

endpackage

`default_nettype wire

[rtl/tga_rle_scanline_decoder_unit.sv]
// ----------------------------------------------------------------------------
// TGA RLE scanline decoder
// Decodes a Targa run-length pixel stream, one encoded byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one byte of the encoded stream per beat. The m_
//   channel delivers one run per beat: pixel and run length in m_tdata,
//   line end on m_tlast, image end and decode error in m_tuser. A header
//   byte that fits the line and the leading bytes of a pixel produce no output beat.
//   The configuration channel writes line length, pixel size and image
//   height; it is always ready and should only be written while idle.
//   The beat that completes a pixel (or an error) appears on the m_
//   channel in the next cycle. Throughput is one input byte per cycle
//   while the receiver keeps up, set by the single result register.
//   While the receiver stalls, the result register holds, and a new byte is
//   taken only in a cycle in which that register is empty or being emptied.
//   Reset clears all decoder state, loads the register defaults (256 pixels
//   per line, 4 bytes per pixel, 256 lines) and empties the result register.
//   After a line overrun every byte yields an error beat until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_scanline_decoder_unit
  import tga_rle_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,    // data_byte[7:0]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,    // pixel[31:0], run_length[39:32]
  output logic                        m_tlast,    // line_end
  output logic [OUT_USER_W-1:0]       m_tuser,    // image_end[0], decode_error[1]
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1
  } phase_t;

  logic [15:0] line_length;
  logic [2:0]  pixel_size;
  logic [15:0] image_height;

  phase_t      phase, phase_next;
  logic        packet_is_repeat, packet_is_repeat_next;
  logic [7:0]  pixels_left, pixels_left_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [31:0] pixel_acc, pixel_acc_next;
  logic [15:0] pixels_done, pixels_done_next;
  logic [15:0] lines_done, lines_done_next;
  logic        error_latched, error_latched_next;

  logic        res_valid;
  logic [31:0] res_pixel;
  logic [7:0]  res_run;
  logic        res_line_end;
  logic        res_image_end;
  logic        res_error;

  logic        in_accept;
  logic [7:0]  hdr_count;
  logic [16:0] hdr_span;
  logic [31:0] acc_merged;
  logic [2:0]  pix_bytes;
  logic [15:0] done_sum;
  logic [15:0] lines_inc;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (pixel_size < 3'd2) begin
      pix_bytes = 3'd2;
    end else if (pixel_size > 3'd4) begin
      pix_bytes = 3'd4;
    end else begin
      pix_bytes = pixel_size;
    end
  end

  assign hdr_count  = (s_tdata & COUNT_MASK) + 8'd1;
  assign hdr_span   = {1'b0, pixels_done} + {9'd0, hdr_count};
  assign acc_merged = pixel_acc | ({24'd0, s_tdata} << {byte_in_pixel, 3'b000});
  assign lines_inc  = lines_done + 16'd1;

  always_comb begin
    phase_next            = phase;
    packet_is_repeat_next = packet_is_repeat;
    pixels_left_next      = pixels_left;
    byte_in_pixel_next    = byte_in_pixel;
    pixel_acc_next        = pixel_acc;
    pixels_done_next      = pixels_done;
    lines_done_next       = lines_done;
    error_latched_next    = error_latched;
    res_valid             = 1'b0;
    res_pixel             = 32'd0;
    res_run               = 8'd0;
    res_line_end          = 1'b0;
    res_image_end         = 1'b0;
    res_error             = 1'b0;
    done_sum              = 16'd0;

    if (error_latched) begin
      res_valid = 1'b1;
      res_error = 1'b1;
    end else if (phase == PH_HEADER) begin
      if (hdr_span > {1'b0, line_length}) begin
        error_latched_next = 1'b1;
        res_valid          = 1'b1;
        res_error          = 1'b1;
      end else begin
        packet_is_repeat_next = (s_tdata & REPEAT_BIT) != 8'd0;
        pixels_left_next      = hdr_count;
        byte_in_pixel_next    = 2'd0;
        pixel_acc_next        = 32'd0;
        phase_next            = PH_PIXEL;
      end
    end else if (({1'b0, byte_in_pixel} + 3'd1) < pix_bytes) begin
      byte_in_pixel_next = byte_in_pixel + 2'd1;
      pixel_acc_next     = acc_merged;
    end else begin
      res_valid          = 1'b1;
      res_pixel          = acc_merged;
      byte_in_pixel_next = 2'd0;
      pixel_acc_next     = 32'd0;
      if (packet_is_repeat) begin
        res_run          = pixels_left;
        pixels_left_next = 8'd0;
      end else begin
        res_run          = 8'd1;
        pixels_left_next = pixels_left - 8'd1;
      end
      if (pixels_left_next == 8'd0) begin
        phase_next = PH_HEADER;
      end
      done_sum         = pixels_done + {8'd0, res_run};
      pixels_done_next = done_sum;
      if (done_sum == line_length) begin
        res_line_end     = 1'b1;
        pixels_done_next = 16'd0;
        lines_done_next  = lines_inc;
        if (lines_inc == image_height) begin
          res_image_end   = 1'b1;
          lines_done_next = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length      <= LINE_LENGTH_RST;
      pixel_size       <= PIXEL_SIZE_RST;
      image_height     <= IMAGE_HEIGHT_RST;
      phase            <= PH_HEADER;
      packet_is_repeat <= 1'b0;
      pixels_left      <= 8'd0;
      byte_in_pixel    <= 2'd0;
      pixel_acc        <= 32'd0;
      pixels_done      <= 16'd0;
      lines_done       <= 16'd0;
      error_latched    <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINE_LENGTH:  line_length  <= cfg_data;
          REG_PIXEL_SIZE:   pixel_size   <= cfg_data[2:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        phase            <= phase_next;
        packet_is_repeat <= packet_is_repeat_next;
        pixels_left      <= pixels_left_next;
        byte_in_pixel    <= byte_in_pixel_next;
        pixel_acc        <= pixel_acc_next;
        pixels_done      <= pixels_done_next;
        lines_done       <= lines_done_next;
        error_latched    <= error_latched_next;
        m_tvalid         <= res_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The result payload only loads alongside a new input byte.
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      m_tdata <= {res_run, res_pixel};
      m_tlast <= res_line_end;
      m_tuser <= {res_error, res_image_end};
    end
  end

endmodule

`default_nettype wire

[rtl/tga_rle_chk.sv]
// ----------------------------------------------------------------------------
// TGA RLE decoder checker
// Port-level assertions for the scanline decoder, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tga_rle_scanline_decoder_unit_assert.svh"

module tga_rle_chk
  import tga_rle_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tlast,
  input wire logic [OUT_USER_W-1:0] m_tuser
);

  logic error_seen;

  // Remembers that an error beat has been delivered since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser[1]) begin
      error_seen <= 1'b1;
    end
  end

  `TGA_RLE_ASSERT_NOW(a_error_sticky, clk, rst, m_tvalid && error_seen, m_tuser[1], "error beat followed by a non-error beat")
  `TGA_RLE_ASSERT_NOW(a_error_payload, clk, rst, m_tvalid && m_tuser[1], (m_tdata == '0) && !m_tlast && !m_tuser[0], "error beat carries payload")
  `TGA_RLE_ASSERT_NOW(a_run_nonzero, clk, rst, m_tvalid && !m_tuser[1], (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128), "run length outside one to 128")
  `TGA_RLE_ASSERT_NOW(a_image_end_line_end, clk, rst, m_tvalid && m_tuser[0], m_tlast, "image end without line end")
  `TGA_RLE_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")

endmodule

bind tga_rle_scanline_decoder_unit tga_rle_chk u_tga_rle_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[test/tga_rle_run_checker.sv]
// ----------------------------------------------------------------------------
// TGA RLE decoder run checker
// Watches the byte, run and register channels of the scanline decoder,
// predicts every run beat from the accepted bytes and compares the beats
// that come out, field by field, in order.
// ----------------------------------------------------------------------------
module tga_rle_run_checker
  import tga_rle_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [7:0]             s_tdata,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [OUT_DATA_W-1:0]  m_tdata,
  input  wire logic                   m_tlast,
  input  wire logic [OUT_USER_W-1:0]  m_tuser,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          errors,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    HDR_WAIT = 2'd0,
    PIX_WAIT = 2'd1
  } decode_phase_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  run_length;
    logic        line_end;
    logic        image_end;
    logic        decode_error;
  } run_beat_t;

  logic [15:0]   line_len;
  logic [2:0]    pix_size;
  logic [15:0]   img_height;
  decode_phase_t phase;
  logic          rep_pkt;
  logic [7:0]    pix_left;
  logic [1:0]    byte_idx;
  logic [31:0]   acc;
  logic [15:0]   col;
  logic [15:0]   row;
  logic          stuck;
  run_beat_t     runs_due[$];

  // Advances the decoder by one stream byte; returns 1 when a run beat is due.
  function automatic bit decode_byte(input logic [7:0] b, output run_beat_t beat);
    logic [16:0] span;
    logic [2:0]  bpp;
    logic [7:0]  run;
    beat = '0;
    if (stuck) begin
      beat.decode_error = 1'b1;
      return 1'b1;
    end
    if (phase == HDR_WAIT) begin
      span = col + (b & COUNT_MASK) + 17'd1;
      if (span > line_len) begin
        stuck = 1'b1;
        beat.decode_error = 1'b1;
        return 1'b1;
      end
      rep_pkt  = (b & REPEAT_BIT) != 8'h00;
      pix_left = (b & COUNT_MASK) + 8'd1;
      byte_idx = 2'd0;
      acc      = '0;
      phase    = PIX_WAIT;
      return 1'b0;
    end
    acc = acc | (32'(b) << (8 * byte_idx));
    bpp = (pix_size < 3'd2) ? 3'd2 : (pix_size > 3'd4) ? 3'd4 : pix_size;
    if (byte_idx + 1 < bpp) begin
      byte_idx++;
      return 1'b0;
    end
    beat.pixel = acc;
    byte_idx   = 2'd0;
    acc        = '0;
    if (rep_pkt) begin
      run      = pix_left;
      pix_left = 8'd0;
    end else begin
      run      = 8'd1;
      pix_left = pix_left - 8'd1;
    end
    if (pix_left == 8'd0) phase = HDR_WAIT;
    beat.run_length = run;
    col = col + 16'(run);
    if (col == line_len) begin
      beat.line_end = 1'b1;
      col = 16'd0;
      row = row + 16'd1;
      if (row == img_height) begin
        beat.image_end = 1'b1;
        row = 16'd0;
      end
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    run_beat_t seen;
    run_beat_t want;
    run_beat_t fresh;
    if (rst) begin
      line_len   = LINE_LENGTH_RST;
      pix_size   = PIXEL_SIZE_RST;
      img_height = IMAGE_HEIGHT_RST;
      phase      = HDR_WAIT;
      rep_pkt    = 1'b0;
      pix_left   = 8'd0;
      byte_idx   = 2'd0;
      acc        = '0;
      col        = 16'd0;
      row        = 16'd0;
      stuck      = 1'b0;
      runs_due.delete();
    end else begin
      // Compare before predicting: a beat can never stem from the byte of this edge.
      if (m_tvalid && m_tready) begin
        seen.pixel        = m_tdata[31:0];
        seen.run_length   = m_tdata[39:32];
        seen.line_end     = m_tlast;
        seen.image_end    = m_tuser[0];
        seen.decode_error = m_tuser[1];
        if (runs_due.size() == 0) begin
          $error("run beat with nothing expected: pixel %0h run %0d error %0b",
                 seen.pixel, seen.run_length, seen.decode_error);
          errors++;
        end else begin
          want = runs_due.pop_front();
          check_field("pixel", want.pixel, seen.pixel);
          check_field("run_length", 32'(want.run_length), 32'(seen.run_length));
          check_field("line_end", 32'(want.line_end), 32'(seen.line_end));
          check_field("image_end", 32'(want.image_end), 32'(seen.image_end));
          check_field("decode_error", 32'(want.decode_error), 32'(seen.decode_error));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_LINE_LENGTH:  line_len   = cfg_data;
          REG_PIXEL_SIZE:   pix_size   = cfg_data[2:0];
          REG_IMAGE_HEIGHT: img_height = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (decode_byte(s_tdata, fresh)) runs_due.push_back(fresh);
      end
    end
    outstanding <= runs_due.size();
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// TGA RLE scanline decoder testbench
// Feeds well-formed run-length packets line by line under a series of
// register settings, with random gaps on both channels and a long receiver
// hold-off, and ends on a deliberate line overrun followed by sticky error
// beats. The run checker predicts and compares every run beat.
// ----------------------------------------------------------------------------
module tb
  import tga_rle_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF    = 60;
  localparam int QUIET_LIMIT = 3000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'h00;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic [OUT_USER_W-1:0]  m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_LINE_LENGTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     chk_errors;
  int                     chk_outstanding;

  // Stream position as the stimulus sees it, so that packets never overrun.
  int gen_len    = 256;
  int gen_bpp    = 4;
  int gen_height = 256;
  int pos        = 0;
  int lines      = 0;
  int sent       = 0;
  int src_idle   = 0;
  int sink_idle  = 0;
  int stall_asks = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tga_rle_scanline_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tga_rle_run_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (chk_errors),
    .outstanding (chk_outstanding)
  );

  task automatic push_byte(input logic [7:0] b);
    if (sent < 650) begin
      src_idle  = 10;
      sink_idle = 66;
    end else if (sent < 1300) begin
      src_idle  = 66;
      sink_idle = 10;
    end else begin
      src_idle  = 0;
      sink_idle = 0;
    end
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // A fill below zero gives random pixel bytes.
  task automatic send_packet(input bit rep, input int n, input int fill);
    int nbytes;
    nbytes = rep ? gen_bpp : n * gen_bpp;
    push_byte((rep ? REPEAT_BIT : 8'h00) | 8'(n - 1));
    repeat (nbytes) push_byte((fill < 0) ? 8'($urandom) : 8'(fill));
    pos += n;
    if (pos == gen_len) begin
      pos = 0;
      lines++;
      if (lines == gen_height) lines = 0;
    end
  endtask

  task automatic run_lines(input int k);
    int ends;
    int room;
    ends = 0;
    while (ends < k) begin
      room = gen_len - pos;
      if (room > 128) room = 128;
      if ($urandom_range(3) != 0) room = $urandom_range(1, room);
      send_packet($urandom_range(1), room, -1);
      if (pos == 0) ends++;
    end
  endtask

  // Waits until every expected run beat has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] len, input logic [2:0] size,
                            input logic [15:0] height);
    cfg_reg_t    regs[3];
    logic [15:0] vals[3];
    regs = '{REG_LINE_LENGTH, REG_PIXEL_SIZE, REG_IMAGE_HEIGHT};
    vals = '{len, 16'(size), height};
    drain();
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    gen_len    = len;
    gen_bpp    = (size < 3'd2) ? 2 : (size > 3'd4) ? 4 : size;
    gen_height = height;
  endtask

  // Receiver: random back-pressure, and a long hold-off whenever one is asked for.
  initial begin
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != stall_asks) begin
        served++;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          ph;
    int          len;
    int          h;
    int          slack;
    logic [7:0]  hdr;
    logic [15:0] err_len;
    ph = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: longest repeat with all ones, shortest with all zeros,
    // then short raw packets, with a receiver hold-off asked for first.
    stall_asks++;
    send_packet(1'b1, 128, 8'hFF);
    send_packet(1'b1, 1, 8'h00);
    send_packet(1'b0, 1, -1);
    send_packet(1'b0, 2, -1);
    run_lines(1);

    // One pixel per line: every run ends a line, every second one an image.
    write_regs(16'd1, 3'd2, 16'd2);
    run_lines(3);

    while (sent < 1350) begin
      ph++;
      if (ph % 9 == 0) begin
        len = $urandom_range(128, 300);
        h   = 1;
      end else begin
        len = $urandom_range(1, 40);
        h   = $urandom_range(1, 4);
      end
      if (h <= lines) h = lines + 1;
      write_regs(16'(len), 3'($urandom_range(0, 7)), 16'(h));
      if (ph % 5 == 0) stall_asks++;
      run_lines(h - lines);
    end

    // Zero image height: lines are counted but no image ever ends.
    write_regs(16'($urandom_range(1, 20)), 3'd7, 16'd0);
    run_lines(3);

    // Widest line and tallest image; the line is left open.
    write_regs(16'hFFFF, 3'd0, 16'hFFFF);
    send_packet(1'b1, 128, -1);
    repeat (7) send_packet($urandom_range(1), $urandom_range(1, 128), -1);

    // Line overrun: zero length, a length already passed, or a packet one too long.
    hdr = 8'($urandom);
    case ($urandom_range(2))
      0: err_len = 16'd0;
      1: err_len = 16'($urandom_range(1, pos - 1));
      default: begin
        slack   = $urandom_range(0, 100);
        err_len = 16'(pos + slack);
        hdr     = ($urandom_range(1) ? REPEAT_BIT : 8'h00) | 8'(slack);
      end
    endcase
    write_regs(err_len, 3'($urandom_range(0, 7)), 16'hFFFF);
    push_byte(hdr);
    // Once in error, every byte must give an error beat.
    repeat (20) push_byte(8'($urandom));
    drain();

    if (chk_errors == 0 && chk_outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
